// ----- src/rtns_pkg.sv -----
// Shared types, widths and helpers for the radix tree node split block.
`timescale 1ns / 1ps
`default_nettype none

package rtns_pkg;

    localparam int CODE_W = 63;   // Morton code width
    localparam int SLOT_W = 10;   // slot and result index width
    localparam int CNT_W  = 11;   // leaf count register width
    // Signed index math: node + probe distance stays below 2^13 for n < 2^11.
    localparam int IDX_W  = 14;

    localparam logic [CNT_W-1:0] LEAF_COUNT_RST = CNT_W'(2);
    localparam logic [0:0]       KIND_LOAD      = 1'b0;
    localparam logic [0:0]       KIND_QUERY     = 1'b1;

    // Datapath micro-operations, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_ACCEPT   = 4'd1,
        OP_BASE     = 4'd2,
        OP_LEFT     = 4'd3,
        OP_RIGHT    = 4'd4,
        OP_GROW     = 4'd5,
        OP_GROW_CHK = 4'd6,
        OP_SRCH     = 4'd7,
        OP_SRCH_CHK = 4'd8,
        OP_ENDS     = 4'd9,
        OP_CF       = 4'd10,
        OP_CL       = 4'd11,
        OP_STEP     = 4'd12,
        OP_STEP_CHK = 4'd13,
        OP_OUT      = 4'd14
    } dp_op_t;

    // Datapath status back to the controller.
    typedef struct packed {
        logic query_go;   // beat is a query with a valid node index
        logic root;       // node 0
        logic probe_in;   // probe address is inside the searched range
        logic hit;        // probe shares a longer prefix than the key
        logic t_zero;     // range search step exhausted
        logic ends_eq;    // first and last codes are equal
        logic more;       // split search has another step
        logic out_free;   // output register can take a result
    } dp_stat_t;

    // True when clz(a) > clz(b), i.e. the top set bit of a is below that of b.
    function automatic logic prefix_longer(input logic [CODE_W-1:0] a,
                                           input logic [CODE_W-1:0] b);
        return (a < b) && (a < (a ^ b));
    endfunction

endpackage

`default_nettype wire

// ----- src/rtns_dp.sv -----
// Datapath: code store, search registers, probe address and result register.
`timescale 1ns / 1ps
`default_nettype none

module rtns_dp
    import rtns_pkg::*;
#(
    parameter int MAX_LEAVES = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_op_t            op,
    output dp_stat_t               st,
    input  wire logic              kind,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [CODE_W-1:0] code,
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic [SLOT_W-1:0]      range_first,
    output logic [SLOT_W-1:0]      range_last,
    output logic [SLOT_W-1:0]      split_at,
    output logic                   left_is_leaf,
    output logic                   right_is_leaf
);

    localparam int AW = $clog2(MAX_LEAVES);

    logic [CODE_W-1:0] mem [MAX_LEAVES];
    logic [CODE_W-1:0] rdata_reg;
    logic [AW-1:0]     raddr;
    logic              mem_we;

    logic [CNT_W-1:0]        leaf_count_reg;
    logic [CNT_W-1:0]        n_eff;
    logic signed [IDX_W-1:0] n_s;

    logic [CODE_W-1:0] ref_reg;   // base code, later the first code
    logic [CODE_W-1:0] xl_reg;
    logic [CODE_W-1:0] key_reg;   // XOR whose prefix length is the threshold
    logic              dir_neg_reg;

    logic signed [IDX_W-1:0] node_reg, lmax_reg, l_reg, t_reg;
    logic signed [IDX_W-1:0] first_reg, last_reg, split_reg, step_reg, ns_reg;

    logic              out_valid_reg;
    logic [SLOT_W-1:0] range_first_reg, range_last_reg, split_at_reg;
    logic              left_leaf_reg, right_leaf_reg;

    logic [CODE_W-1:0]       xr;
    logic                    hit;
    logic signed [IDX_W-1:0] lt_sum, probe, j_idx, step_n, ns_next, rd_idx;
    logic                    probe_in;

    assign n_eff = (32'(leaf_count_reg) > 32'(MAX_LEAVES)) ? CNT_W'(MAX_LEAVES)
                                                           : leaf_count_reg;
    assign n_s   = IDX_W'(n_eff);

    assign xr      = ref_reg ^ rdata_reg;
    assign hit     = prefix_longer(ref_reg ^ rdata_reg, key_reg);
    assign lt_sum  = l_reg + t_reg;
    assign j_idx   = dir_neg_reg ? node_reg - l_reg : node_reg + l_reg;
    assign step_n  = (step_reg + IDX_W'(1)) >>> 1;
    assign ns_next = split_reg + step_n;

    always_comb begin
        probe = '0;
        case (op)
            OP_GROW: probe = dir_neg_reg ? node_reg - lmax_reg : node_reg + lmax_reg;
            OP_SRCH: probe = dir_neg_reg ? node_reg - lt_sum : node_reg + lt_sum;
            default: probe = ns_next;
        endcase
    end

    assign probe_in = (op == OP_STEP) ? (ns_next < last_reg)
                                      : (probe >= 0) && (probe < n_s);

    // Read address per step; data shows up in rdata_reg in the next cycle.
    always_comb begin
        unique case (op)
            OP_ACCEPT: rd_idx = IDX_W'(slot);
            OP_BASE:   rd_idx = node_reg - IDX_W'(1);
            OP_LEFT:   rd_idx = node_reg + IDX_W'(1);
            OP_GROW,
            OP_SRCH,
            OP_STEP:   rd_idx = probe;
            OP_ENDS:   rd_idx = first_reg;
            OP_CF:     rd_idx = last_reg;
            default:   rd_idx = node_reg;
        endcase
    end

    assign raddr  = AW'(rd_idx[IDX_W-2:0]);
    assign mem_we = (op == OP_ACCEPT) && (kind == KIND_LOAD)
                  && (32'(slot) < 32'(MAX_LEAVES));

    always_ff @(posedge clk) begin
        if (mem_we)
        begin
            mem[AW'(slot)] <= code;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            leaf_count_reg <= LEAF_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                leaf_count_reg <= cfg_wr_data;
            end
            if (op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        unique case (op)
            OP_ACCEPT:
            begin
                node_reg  <= IDX_W'(slot);
                first_reg <= '0;
                last_reg  <= n_s - IDX_W'(1);
            end
            OP_BASE: ref_reg <= rdata_reg;
            OP_LEFT: xl_reg <= ref_reg ^ rdata_reg;
            OP_RIGHT:
            begin
                dir_neg_reg <= prefix_longer(xl_reg, xr);
                key_reg     <= prefix_longer(xr, xl_reg) ? xl_reg : xr;
                lmax_reg    <= IDX_W'(2);
            end
            OP_GROW:
            begin
                if (!probe_in)
                begin
                    t_reg <= lmax_reg >>> 1;
                    l_reg <= '0;
                end
            end
            OP_GROW_CHK:
            begin
                if (hit)
                begin
                    lmax_reg <= lmax_reg <<< 1;
                end
                else
                begin
                    t_reg <= lmax_reg >>> 1;
                    l_reg <= '0;
                end
            end
            OP_SRCH:
            begin
                if (t_reg == '0)
                begin
                    first_reg <= dir_neg_reg ? j_idx : node_reg;
                    last_reg  <= dir_neg_reg ? node_reg : j_idx;
                end
                else if (!probe_in)
                begin
                    t_reg <= t_reg >>> 1;
                end
            end
            OP_SRCH_CHK:
            begin
                if (hit)
                begin
                    l_reg <= lt_sum;
                end
                t_reg <= t_reg >>> 1;
            end
            OP_CF: ref_reg <= rdata_reg;
            OP_CL:
            begin
                if (ref_reg == rdata_reg)
                begin
                    split_reg <= (first_reg + last_reg) >>> 1;
                end
                else
                begin
                    key_reg   <= ref_reg ^ rdata_reg;
                    split_reg <= first_reg;
                    step_reg  <= last_reg - first_reg;
                end
            end
            OP_STEP:
            begin
                step_reg <= step_n;
                ns_reg   <= ns_next;
            end
            OP_STEP_CHK:
            begin
                if (hit)
                begin
                    split_reg <= ns_reg;
                end
            end
            OP_OUT:
            begin
                range_first_reg <= first_reg[SLOT_W-1:0];
                range_last_reg  <= last_reg[SLOT_W-1:0];
                split_at_reg    <= split_reg[SLOT_W-1:0];
                left_leaf_reg   <= (split_reg == first_reg);
                right_leaf_reg  <= (split_reg + IDX_W'(1) == last_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        st.query_go = (kind == KIND_QUERY)
                    && (({1'b0, CNT_W'(slot)} + (CNT_W+1)'(2)) <= {1'b0, n_eff});
        st.root     = (slot == '0);
        st.probe_in = probe_in;
        st.hit      = hit;
        st.t_zero   = (t_reg == '0);
        st.ends_eq  = (ref_reg == rdata_reg);
        st.more     = (op == OP_STEP) ? ((step_n >>> 1) != '0) : ((step_reg >>> 1) != '0);
        st.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign range_first   = range_first_reg;
    assign range_last    = range_last_reg;
    assign split_at      = split_at_reg;
    assign left_is_leaf  = left_leaf_reg;
    assign right_is_leaf = right_leaf_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_OUT) |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending beat");

    a_split_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_OUT) |-> (first_reg <= split_reg && split_reg <= last_reg))
        else $error("split outside node range");

endmodule

`default_nettype wire

// ----- src/rtns_ctrl.sv -----
// Controller: sequences range search, split search and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module rtns_ctrl
    import rtns_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire dp_stat_t st,
    output dp_op_t        op
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_BASE     = 14'b00000000000010,
        S_LEFT     = 14'b00000000000100,
        S_RIGHT    = 14'b00000000001000,
        S_GROW     = 14'b00000000010000,
        S_GROW_CHK = 14'b00000000100000,
        S_SRCH     = 14'b00000001000000,
        S_SRCH_CHK = 14'b00000010000000,
        S_ENDS     = 14'b00000100000000,
        S_CF       = 14'b00001000000000,
        S_CL       = 14'b00010000000000,
        S_STEP     = 14'b00100000000000,
        S_STEP_CHK = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_ACCEPT;
                    if (st.query_go)
                    begin
                        state_next = st.root ? S_ENDS : S_BASE;
                    end
                end
            end
            S_BASE:
            begin
                op         = OP_BASE;
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                op         = OP_LEFT;
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                op         = OP_RIGHT;
                state_next = S_GROW;
            end
            S_GROW:
            begin
                op         = OP_GROW;
                state_next = st.probe_in ? S_GROW_CHK : S_SRCH;
            end
            S_GROW_CHK:
            begin
                op         = OP_GROW_CHK;
                state_next = st.hit ? S_GROW : S_SRCH;
            end
            S_SRCH:
            begin
                op = OP_SRCH;
                if (st.t_zero)
                begin
                    state_next = S_ENDS;
                end
                else if (st.probe_in)
                begin
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                op         = OP_SRCH_CHK;
                state_next = S_SRCH;
            end
            S_ENDS:
            begin
                op         = OP_ENDS;
                state_next = S_CF;
            end
            S_CF:
            begin
                op         = OP_CF;
                state_next = S_CL;
            end
            S_CL:
            begin
                op         = OP_CL;
                state_next = st.ends_eq ? S_DONE : S_STEP;
            end
            S_STEP:
            begin
                op = OP_STEP;
                if (st.probe_in)
                begin
                    state_next = S_STEP_CHK;
                end
                else if (!st.more)
                begin
                    state_next = S_DONE;
                end
            end
            S_STEP_CHK:
            begin
                op         = OP_STEP_CHK;
                state_next = st.more ? S_STEP : S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A compare step only follows a read that was inside the searched range.
    a_probe_checked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GROW_CHK || state_reg == S_SRCH_CHK || state_reg == S_STEP_CHK)
        |-> $past(st.probe_in))
        else $error("compare step after out-of-range probe");

endmodule

`default_nettype wire

// ----- src/radix_tree_node_split.sv -----
// Top level of the radix tree node split block.
`timescale 1ns / 1ps
`default_nettype none

// Radix tree node split. Keeps a store of up to MAX_LEAVES sorted 63-bit
// Morton codes and answers queries for internal node i of the binary radix
// tree built over the first leaf_count of them. A load beat (kind 0) writes
// code at slot and gives no result; slots at or past MAX_LEAVES are dropped.
// A query beat (kind 1) gives one result beat with the node's leaf range, its
// split position and the two child leaf flags; a query with slot > n-2 (n is
// leaf_count capped at MAX_LEAVES) gives nothing. Codes read by a query must
// have been loaded first; the store has no reset. The input takes a load
// whenever the block is idle. A query walks the store through its single
// read port and takes no new beat until it is done: three neighbor reads,
// the doubling and binary range search, then two end reads and the split
// binary search. The root skips the neighbor reads and the range search.
// The result sits in an output register, so the next beat is taken while a
// result waits; a query that finishes while that register is still stalled
// holds until it drains. leaf_count resets to 2; the user is to write it
// through cfg_wr_en/cfg_wr_data only while the block is idle, which the
// block itself does not enforce.

module radix_tree_node_split
    import rtns_pkg::*;
#(
    parameter int MAX_LEAVES = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    // input beats
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              kind,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [CODE_W-1:0] code,
    // result beats
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [SLOT_W-1:0]      range_first,
    output logic [SLOT_W-1:0]      range_last,
    output logic [SLOT_W-1:0]      split_at,
    output logic                   left_is_leaf,
    output logic                   right_is_leaf
);

    dp_op_t   op;
    dp_stat_t st;

    rtns_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .op       (op)
    );

    rtns_dp #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .st            (st),
        .kind          (kind),
        .slot          (slot),
        .code          (code),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .range_first   (range_first),
        .range_last    (range_last),
        .split_at      (split_at),
        .left_is_leaf  (left_is_leaf),
        .right_is_leaf (right_is_leaf)
    );

endmodule

`default_nettype wire

// ----- dv/tb_radix_tree_node_split.sv -----
// Self-checking testbench for the radix tree node split block.
`timescale 1ns / 1ps

typedef struct packed {
    logic [rtns_pkg::SLOT_W-1:0] lo;
    logic [rtns_pkg::SLOT_W-1:0] hi;
    logic [rtns_pkg::SLOT_W-1:0] split;
    logic                        left_leaf;
    logic                        right_leaf;
} node_split_t;

// Mirror of the code store and leaf count, plus the splits still owed by the block.
class split_board;
    logic [rtns_pkg::CODE_W-1:0] mem [1024];   // sized for MAX_LEAVES of the instance
    logic [rtns_pkg::CNT_W-1:0]  leaf_count;
    int                          max_leaves;
    node_split_t                 due [$];
    int                          errors;

    function new(int depth);
        max_leaves = depth;
        leaf_count = rtns_pkg::LEAF_COUNT_RST;
        errors = 0;
    endfunction

    task report(string what);
        $display("%0t ns mismatch: %s", $time, what);
        errors++;
    endtask

    function int pending();
        return due.size();
    endfunction

    // leading zeros of a 63-bit word, 63 for zero
    function int lz63(logic [rtns_pkg::CODE_W-1:0] x);
        for (int b = rtns_pkg::CODE_W - 1; b >= 0; b--)
        begin
            if (x[b])
                return rtns_pkg::CODE_W - 1 - b;
        end
        return rtns_pkg::CODE_W;
    endfunction

    // common prefix with leaf j, -1 past either end of the leaves
    function int shared_len(logic [rtns_pkg::CODE_W-1:0] key, int j, int n);
        if (j < 0 || j >= n)
            return -1;
        return lz63(key ^ mem[j]);
    endfunction

    function bit predict(int node, output node_split_t r);
        int n, dl, dr, dir, dmin, reach, span, far, lo, hi, split, stride, probe, dnode;
        logic [rtns_pkg::CODE_W-1:0] key, c_lo, c_hi;
        r = '0;
        n = (leaf_count > max_leaves) ? max_leaves : int'(leaf_count);
        if (n < 2 || node > n - 2)
            return 0;
        if (node == 0)
        begin
            lo = 0;
            hi = n - 1;
        end
        else
        begin
            key = mem[node];
            dl = shared_len(key, node - 1, n);
            dr = shared_len(key, node + 1, n);
            dir = (dl > dr) ? -1 : 1;   // tie goes right
            dmin = (dl < dr) ? dl : dr;
            reach = 2;
            while (shared_len(key, node + reach * dir, n) > dmin)
                reach *= 2;
            span = 0;
            for (int t = reach / 2; t >= 1; t /= 2)
            begin
                if (shared_len(key, node + (span + t) * dir, n) > dmin)
                    span += t;
            end
            far = node + span * dir;
            lo = (far < node) ? far : node;
            hi = (far < node) ? node : far;
        end
        c_lo = mem[lo];
        c_hi = mem[hi];
        if (c_lo == c_hi)
            split = (lo + hi) / 2;
        else
        begin
            dnode = lz63(c_lo ^ c_hi);
            stride = hi - lo;
            split = lo;
            do
            begin
                stride = (stride + 1) / 2;
                probe = split + stride;
                if (probe < hi && lz63(c_lo ^ mem[probe]) > dnode)
                    split = probe;
            end
            while (stride > 1);
        end
        r.lo = lo[rtns_pkg::SLOT_W-1:0];
        r.hi = hi[rtns_pkg::SLOT_W-1:0];
        r.split = split[rtns_pkg::SLOT_W-1:0];
        r.left_leaf = (split == lo);
        r.right_leaf = (split + 1 == hi);
        return 1;
    endfunction

    function void note_beat(logic k, logic [rtns_pkg::SLOT_W-1:0] s,
                            logic [rtns_pkg::CODE_W-1:0] c);
        node_split_t r;
        if (k == rtns_pkg::KIND_LOAD)
        begin
            if (int'(s) < max_leaves)
                mem[s] = c;
        end
        else if (predict(int'(s), r))
            due.insert(due.size(), r);
    endfunction

    task check_result(node_split_t got);
        node_split_t want;
        if (due.size() == 0)
        begin
            report($sformatf("result first=%0d last=%0d split=%0d with none pending",
                             got.lo, got.hi, got.split));
            return;
        end
        want = due.pop_front();
        if (got.lo != want.lo)
            report($sformatf("range_first got %0d want %0d", got.lo, want.lo));
        if (got.hi != want.hi)
            report($sformatf("range_last got %0d want %0d", got.hi, want.hi));
        if (got.split != want.split)
            report($sformatf("split_at got %0d want %0d", got.split, want.split));
        if (got.left_leaf != want.left_leaf)
            report($sformatf("left_is_leaf got %0b want %0b", got.left_leaf, want.left_leaf));
        if (got.right_leaf != want.right_leaf)
            report($sformatf("right_is_leaf got %0b want %0b",
                             got.right_leaf, want.right_leaf));
    endtask

    task close_out();
        if (due.size() != 0)
            report($sformatf("%0d results never arrived", due.size()));
    endtask
endclass

module tb_radix_tree_node_split;
    import rtns_pkg::*;

    localparam int LEAVES       = 1024;
    localparam int ITEM_GOAL    = 1150;   // input beats over the whole run
    localparam int CALM_ITEMS   = 80;     // trailing beats with no idling
    localparam int DRAIN_CYCLES = 100;    // above the worst query latency
    localparam int HOLD_CYCLES  = 300;    // long output hold-off to back up the input
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data = LEAF_COUNT_RST;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              kind = KIND_LOAD;
    logic [SLOT_W-1:0] slot = '0;
    logic [CODE_W-1:0] code = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [SLOT_W-1:0] range_first;
    logic [SLOT_W-1:0] range_last;
    logic [SLOT_W-1:0] split_at;
    logic              left_is_leaf;
    logic              right_is_leaf;

    split_board sb;
    int         items_sent = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    bit         calm = 1'b0;      // no idling on either side once set
    bit         hold_req = 1'b0;  // asks the result side for one long hold-off

    radix_tree_node_split #(
        .MAX_LEAVES(LEAVES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .slot(slot),
        .code(code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .range_first(range_first),
        .range_last(range_last),
        .split_at(split_at),
        .left_is_leaf(left_is_leaf),
        .right_is_leaf(right_is_leaf)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_radix_tree_node_split: done, errors");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int idle_pick();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 20;
            default: return 50;
        endcase
    endfunction

    // Codes for the small directed tree: runs of duplicates, both extremes,
    // and a lone code far from its neighbors.
    function automatic logic [CODE_W-1:0] seed_code(int k);
        case (k)
            3: return 63'd3;
            4: return 63'd4;
            5: return 63'h2000_0000_0000_0000;
            6, 7: return CODE_MAX;
            default: return '0;
        endcase
    endfunction

    // One input beat: hold it until taken, then record it in the mirror.
    task automatic send_beat(input logic k, input logic [SLOT_W-1:0] s,
                             input logic [CODE_W-1:0] c);
        in_valid <= 1'b1;
        kind <= k;
        slot <= s;
        code <= c;
        do @(posedge clk); while (in_stall);
        sb.note_beat(k, s, c);
        items_sent++;
    endtask

    task automatic pace_tx();
        if (!calm && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Quiet the input, let every owed result drain, then give a trailing
    // load-only stretch time to finish before touching the register.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_leaf_count(input logic [CNT_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.leaf_count = v;
    endtask

    // Ascending codes with a random step size, a quarter of them repeats.
    // Wide steps saturate at the top code, which gives duplicates there too.
    task automatic load_sorted(input int n, input int top);
        logic [63:0] acc, mask;
        mask = (64'd1 << top) - 64'd1;
        acc = rand_word() & mask;
        for (int s = 0; s < n; s++)
        begin
            if (s > 0 && $urandom_range(0, 3) != 0)
            begin
                acc = acc + 64'd1 + (rand_word() & (mask >> $urandom_range(0, top)));
                if (acc > {1'b0, CODE_MAX})
                    acc = {1'b0, CODE_MAX};
            end
            pace_tx();
            send_beat(KIND_LOAD, SLOT_W'(s), acc[CODE_W-1:0]);
        end
    endtask

    // Mostly in-range queries; some stray loads and out-of-range node indexes.
    task automatic random_item(input int n);
        int r;
        logic [63:0] w;
        r = $urandom_range(0, 99);
        w = rand_word();
        pace_tx();
        if (r < 8)
            send_beat(KIND_LOAD, SLOT_W'($urandom_range(0, LEAVES - 1)), w[CODE_W-1:0]);
        else if (r < 14 || n < 2)
            send_beat(KIND_QUERY, SLOT_W'($urandom_range((n > 1) ? n - 1 : 0, LEAVES - 1)),
                      w[CODE_W-1:0]);
        else
            send_beat(KIND_QUERY, SLOT_W'($urandom_range(0, n - 2)), w[CODE_W-1:0]);
    endtask

    // top < 0 keeps the store as it is
    task automatic run_phase(input int lc, input int top, input int nq, input bit hold);
        int n;
        n = (lc > LEAVES) ? LEAVES : lc;
        settle();
        write_leaf_count(CNT_W'(lc));
        tx_idle_pct = calm ? 0 : idle_pick();
        rx_idle_pct = calm ? 0 : idle_pick();
        if (top >= 0)
            load_sorted(n, top);
        if (hold)
            hold_req = 1'b1;
        repeat (nq) random_item(n);
    endtask

    task automatic directed();
        // reset leaf count of two: equal end codes, root splits at the midpoint
        send_beat(KIND_LOAD, '0, CODE_MAX);
        send_beat(KIND_LOAD, SLOT_W'(1), CODE_MAX);
        send_beat(KIND_QUERY, '0, '0);
        send_beat(KIND_QUERY, SLOT_W'(1), '0);
        // fewer than two leaves: no node answers
        settle();
        write_leaf_count(CNT_W'(0));
        send_beat(KIND_QUERY, '0, CODE_MAX);
        settle();
        write_leaf_count(CNT_W'(1));
        send_beat(KIND_QUERY, SLOT_W'(LEAVES - 1), '0);
        // eight leaves with duplicate runs: tie goes right, collapsed ranges,
        // searches that run off either end of the leaves
        settle();
        write_leaf_count(CNT_W'(8));
        for (int k = 0; k < 8; k++)
            send_beat(KIND_LOAD, SLOT_W'(k), seed_code(k));
        send_beat(KIND_LOAD, SLOT_W'(LEAVES - 1), 63'h5555_5555_5555_5555);
        for (int k = 0; k < 8; k++)
            send_beat(KIND_QUERY, SLOT_W'(k), '0);
        send_beat(KIND_QUERY, SLOT_W'(LEAVES - 1), '0);
    endtask

    // Result side: check every taken beat against the oldest owed split,
    // stall in short bursts, and once in a long hold-off on request.
    initial
    begin
        int hold_left, burst_left;
        node_split_t got;
        hold_left = 0;
        burst_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.lo = range_first;
                got.hi = range_last;
                got.split = split_at;
                got.left_leaf = left_is_leaf;
                got.right_leaf = right_is_leaf;
                sb.check_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < rx_idle_pct)
            begin
                burst_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int lc, r, nq;
        sb = new(LEAVES);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();

        // full store, then the capped count and a mid size over the same codes
        run_phase(LEAVES, $urandom_range(44, 53), 30, 1'b1);
        run_phase((1 << CNT_W) - 1, -1, 12, 1'b0);
        run_phase($urandom_range(3, LEAVES - 1), -1, 12, 1'b0);

        // small trees, reloaded each time, up to the beat budget
        while (items_sent < ITEM_GOAL)
        begin
            calm = (items_sent > ITEM_GOAL - CALM_ITEMS);
            r = $urandom_range(0, 99);
            if (r < 4)
                lc = $urandom_range(0, 1);
            else if (r < 70)
                lc = $urandom_range(2, 16);
            else if (r < 95)
                lc = $urandom_range(17, 64);
            else
                lc = $urandom_range(65, 200);
            nq = (lc < 2) ? 3 : $urandom_range(4, (3 * lc > 40) ? 40 : 3 * lc);
            run_phase(lc, $urandom_range(0, 62), nq, 1'b0);
        end

        settle();
        sb.close_out();
        if (sb.errors == 0)
            $display("tb_radix_tree_node_split: done, clean");
        else
            $display("tb_radix_tree_node_split: done, errors");
        $finish;
    end

endmodule

// ----- radix_tree_node_split.f -----
src/rtns_pkg.sv
src/rtns_dp.sv
src/rtns_ctrl.sv
src/radix_tree_node_split.sv
dv/tb_radix_tree_node_split.sv
